>>> rtl/core/skt_pkg.sv
// sorted key table package: opcodes, status codes, sequencer states
// no dependencies
package skt_pkg;

    typedef enum logic [1:0] {
        t_op_append = 2'd0,
        t_op_find   = 2'd1,
        t_op_rmkey  = 2'd2,
        t_op_rmpos  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        t_st_ok      = 2'd0,
        t_st_missing = 2'd1,
        t_st_range   = 2'd2,
        t_st_reject  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    localparam int KEY_BITS = 64;

endpackage

>>> rtl/core/skt_store.sv
// sorted key table storage: key and payload memories, one write and one
// registered read port each; uses skt_pkg
module skt_store #(
    parameter int DEPTH = 64,
    parameter int PW    = 32,
    parameter int AW    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [skt_pkg::KEY_BITS-1:0] i_wkey,
    input  logic [PW-1:0]               i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [skt_pkg::KEY_BITS-1:0] o_rkey,
    output logic [PW-1:0]               o_rdata
);
    logic [skt_pkg::KEY_BITS-1:0] r_keys [DEPTH];
    logic [PW-1:0]                r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_waddr] <= i_wkey;
            r_data[i_waddr] <= i_wdata;
        end
        o_rkey  <= r_keys[i_raddr];
        o_rdata <= r_data[i_raddr];
    end
endmodule

>>> rtl/core/sorted_key_table.sv
// sorted key table top level: sequencer around one compare unit and memory
// uses skt_pkg and skt_store
//
// A table of up to TABLE_DEPTH (key, payload) entries in ascending key
// order. One transaction at a time: append makes one memory read of the
// last key, find makes one memory read per binary-search probe, and a
// removal moves every later entry down one place, with a read and a write
// for each entry moved. All steps share the single memory read port and
// the one 64-bit comparator. The result sits in an output register;
// i_stall holds it.
module sorted_key_table #(
    parameter int TABLE_DEPTH  = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_key,
    input  logic [5:0]  i_position,
    input  logic [31:0] i_entry_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [5:0]  o_found_position,
    output logic [31:0] o_found_data,
    output logic [6:0]  o_entry_total
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    skt_pkg::t_state r_state, n_state;

    // captured transaction
    logic [1:0]               r_op;
    logic [63:0]              r_key;
    logic [5:0]               r_pos;
    logic [PAYLOAD_BITS-1:0]  r_pay;

    // search window and count
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_cnt, n_cnt;
    logic [CW-1:0] r_ptr, n_ptr;      // probe or shift pointer

    // result register
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_st, n_st;
    logic        r_fnd, n_fnd;
    logic [AW-1:0] r_fpos, n_fpos;
    logic [PAYLOAD_BITS-1:0] r_fdat, n_fdat;

    // memory port
    logic                    m_we;
    logic [AW-1:0]           m_waddr, m_raddr;
    logic [63:0]             m_wkey, m_rkey;
    logic [PAYLOAD_BITS-1:0] m_wdata, m_rdata;

    logic [CW-1:0] w_mid;
    logic          w_eq, w_lt;

    skt_store #(.DEPTH(TABLE_DEPTH), .PW(PAYLOAD_BITS), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wkey (m_wkey),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rkey (m_rkey),
        .o_rdata(m_rdata)
    );

    // the shared compare unit
    assign w_eq  = (m_rkey == r_key);
    assign w_lt  = (m_rkey < r_key);
    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    assign o_stall = (r_state != skt_pkg::S_IDLE) || r_ovalid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            skt_pkg::S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_state = skt_pkg::S_READ;
                end
            end
            skt_pkg::S_READ: begin
                n_state = skt_pkg::S_EVAL;
                case (r_op)
                    skt_pkg::t_op_append: begin
                        if (r_cnt == CW'(TABLE_DEPTH) || r_cnt == '0) begin
                            n_state = skt_pkg::S_DONE;
                        end
                    end
                    skt_pkg::t_op_rmpos: begin
                        if (CW'(r_pos) >= r_cnt) begin
                            n_state = skt_pkg::S_DONE;
                        end
                    end
                    default: begin
                        if (r_lo >= r_hi) begin
                            n_state = skt_pkg::S_DONE;
                        end
                    end
                endcase
            end
            skt_pkg::S_EVAL: begin
                case (r_op)
                    skt_pkg::t_op_append: n_state = skt_pkg::S_DONE;
                    skt_pkg::t_op_rmpos:  n_state = skt_pkg::S_SHIFT_RD;
                    skt_pkg::t_op_find: begin
                        n_state = w_eq ? skt_pkg::S_DONE : skt_pkg::S_READ;
                    end
                    default: begin
                        n_state = w_eq ? skt_pkg::S_SHIFT_RD : skt_pkg::S_READ;
                    end
                endcase
            end
            skt_pkg::S_SHIFT_RD: begin
                n_state = (r_ptr + 1'b1 < r_cnt) ? skt_pkg::S_SHIFT_WR
                                                 : skt_pkg::S_DONE;
            end
            skt_pkg::S_SHIFT_WR: n_state = skt_pkg::S_SHIFT_RD;
            skt_pkg::S_DONE: n_state = skt_pkg::S_IDLE;
            default: n_state = skt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_ovalid = r_ovalid && i_stall;
        n_st     = r_st;
        n_fnd    = r_fnd;
        n_fpos   = r_fpos;
        n_fdat   = r_fdat;
        m_we     = 1'b0;
        m_waddr  = r_ptr[AW-1:0];
        m_wkey   = m_rkey;
        m_wdata  = m_rdata;
        m_raddr  = r_ptr[AW-1:0];
        case (r_state)
            skt_pkg::S_IDLE: begin
                n_lo = '0;
                n_hi = r_cnt;
                // a waiting result stays put until the new transaction starts
                if (i_valid && !o_stall) begin
                    n_st = skt_pkg::t_st_ok;
                    n_fnd = 1'b0;
                    n_fpos = '0;
                    n_fdat = '0;
                end
            end
            skt_pkg::S_READ: begin
                case (r_op)
                    skt_pkg::t_op_append: begin
                        m_raddr = AW'(r_cnt - 1'b1);
                        if (r_cnt == CW'(TABLE_DEPTH)) begin
                            n_st = skt_pkg::t_st_reject;
                        end
                    end
                    skt_pkg::t_op_rmpos: begin
                        m_raddr = AW'(r_pos);
                        n_ptr   = CW'(r_pos);
                        if (CW'(r_pos) >= r_cnt) begin
                            n_st = skt_pkg::t_st_range;
                        end
                    end
                    default: begin
                        m_raddr = w_mid[AW-1:0];
                        n_ptr   = w_mid;
                        if (r_lo >= r_hi) begin
                            n_st = skt_pkg::t_st_missing;
                        end
                    end
                endcase
            end
            skt_pkg::S_EVAL: begin
                case (r_op)
                    skt_pkg::t_op_append: begin
                        if (!w_lt) begin
                            n_st = skt_pkg::t_st_reject;
                        end
                    end
                    skt_pkg::t_op_rmpos: begin
                        n_fnd  = 1'b1;
                        n_fpos = r_ptr[AW-1:0];
                        n_fdat = m_rdata;
                    end
                    default: begin
                        if (w_eq) begin
                            n_fnd  = 1'b1;
                            n_fpos = r_ptr[AW-1:0];
                            n_fdat = m_rdata;
                        end else if (w_lt) begin
                            n_lo = r_ptr + 1'b1;
                        end else begin
                            n_hi = r_ptr;
                        end
                    end
                endcase
            end
            skt_pkg::S_SHIFT_RD: begin
                m_raddr = AW'(r_ptr + 1'b1);
            end
            skt_pkg::S_SHIFT_WR: begin
                m_we    = 1'b1;
                m_waddr = r_ptr[AW-1:0];
                n_ptr   = r_ptr + 1'b1;
            end
            skt_pkg::S_DONE: begin
                n_ovalid = 1'b1;
                if (n_st == skt_pkg::t_st_ok) begin
                    if (r_op == skt_pkg::t_op_append) begin
                        m_we    = 1'b1;
                        m_waddr = r_cnt[AW-1:0];
                        m_wkey  = r_key;
                        m_wdata = r_pay;
                        n_fpos  = r_cnt[AW-1:0];
                        n_cnt   = r_cnt + 1'b1;
                    end else if (r_op != skt_pkg::t_op_find) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= skt_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == skt_pkg::S_IDLE && i_valid && !o_stall) begin
            r_op  <= i_opcode;
            r_key <= i_key;
            r_pos <= i_position;
            r_pay <= PAYLOAD_BITS'(i_entry_data);
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_ptr  <= n_ptr;
        r_st   <= n_st;
        r_fnd  <= n_fnd;
        r_fpos <= n_fpos;
        r_fdat <= n_fdat;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_st;
    assign o_found          = r_fnd;
    assign o_found_position = 6'(r_fpos);
    assign o_found_data     = 32'(r_fdat);
    assign o_entry_total    = 7'(r_cnt);
endmodule

>>> rtl/core/skt_checker.sv
// sorted key table port checker and bind
// sees only top-level ports; uses skt_pkg
module skt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic        o_found,
    input logic [6:0]  o_entry_total
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("accepting while result pending");
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_status == skt_pkg::t_st_ok)
        else $error("found with error status");
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_total <= 7'd64)
        else $error("count overflow");
endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_found(o_found), .o_entry_total(o_entry_total)
);

>>> tb/sorted_key_table_test.sv
`timescale 1ns / 1ps
// self-checking bench for sorted_key_table: random and directed table operations
// depends on skt_pkg and the sorted_key_table rtl
module sorted_key_table_test;

    localparam int DEPTH = 64;

    typedef struct packed {
        skt_pkg::t_opcode op;
        logic [63:0]      key;
        logic [5:0]       pos;
        logic [31:0]      data;
    } t_op_item;

    typedef struct packed {
        skt_pkg::t_status status;
        logic             found;
        logic [5:0]       fpos;
        logic [31:0]      fdata;
        logic [6:0]       total;
    } t_op_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [63:0] i_key = '0;
    logic [5:0]  i_position = '0;
    logic [31:0] i_entry_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_found;
    logic [5:0]  o_found_position;
    logic [31:0] o_found_data;
    logic [6:0]  o_entry_total;

    sorted_key_table dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow copy of the table contents
    logic [63:0] shadow_keys [DEPTH];
    logic [31:0] shadow_data [DEPTH];
    int          shadow_count = 0;

    t_op_item   pending_ops[$];
    t_op_result expected_results[$];
    int         fail_count = 0;
    bit         quiet = 1'b0;    // no idling; set while the op list is built, so it holds for the whole run

    // remove entry at p, closing the gap
    task automatic shadow_drop(int p);
        for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_data[i] = shadow_data[i + 1];
        end
        shadow_count--;
    endtask

    // predicts one result and updates the shadow table
    task automatic apply_table_op(t_op_item it);
        t_op_result r;
        int lo, hi, mid, hit;
        r = '{status: skt_pkg::t_st_ok, found: 1'b0, fpos: '0, fdata: '0, total: '0};
        hit = -1;
        case (it.op)
            skt_pkg::t_op_append: begin
                if (shadow_count >= DEPTH ||
                    (shadow_count > 0 && it.key <= shadow_keys[shadow_count - 1])) begin
                    r.status = skt_pkg::t_st_reject;
                end else begin
                    shadow_keys[shadow_count] = it.key;
                    shadow_data[shadow_count] = it.data;
                    r.fpos = shadow_count[5:0];
                    shadow_count++;
                end
            end
            skt_pkg::t_op_find, skt_pkg::t_op_rmkey: begin
                lo = 0;
                hi = shadow_count;
                while (lo < hi && hit < 0) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_keys[mid] == it.key) hit = mid;
                    else if (shadow_keys[mid] < it.key) lo = mid + 1;
                    else hi = mid;
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.fpos  = hit[5:0];
                    r.fdata = shadow_data[hit];
                    if (it.op == skt_pkg::t_op_rmkey) shadow_drop(hit);
                end else begin
                    r.status = skt_pkg::t_st_missing;
                end
            end
            default: begin
                if (it.pos < shadow_count) begin
                    r.found = 1'b1;
                    r.fpos  = it.pos;
                    r.fdata = shadow_data[it.pos];
                    shadow_drop(it.pos);
                end else begin
                    r.status = skt_pkg::t_st_range;
                end
            end
        endcase
        r.total = shadow_count[6:0];
        expected_results.push_back(r);
    endtask

    // keys the stimulus generator believes are stored, to aim finds and removes
    logic [63:0] gen_keys[$];
    logic [63:0] gen_top = '0;

    function automatic t_op_item mk(skt_pkg::t_opcode op, logic [63:0] key,
                                    logic [5:0] pos, logic [31:0] data);
        t_op_item it;
        it.op = op;
        it.key = key;
        it.pos = pos;
        it.data = data;
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // driver: holds payload while stalled; idles in bursts only while quiet is clear
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    t_op_item it;
                    it = pending_ops.pop_front();
                    i_valid      <= 1'b1;
                    i_opcode     <= it.op;
                    i_key        <= it.key;
                    i_position   <= it.pos;
                    i_entry_data <= it.data;
                    apply_table_op(it);
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 8);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result transaction and drives the output stall
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction", $time);
                    fail_count++;
                end else begin
                    t_op_result e;
                    e = expected_results.pop_front();
                    if (o_status !== e.status || o_found !== e.found ||
                        o_found_position !== e.fpos || o_found_data !== e.fdata ||
                        o_entry_total !== e.total) begin
                        $display("%0t: mismatch expected st=%0d f=%0d p=%0d d=%h n=%0d",
                                 $time, e.status, e.found, e.fpos, e.fdata, e.total);
                        $display("%0t:          actual   st=%0d f=%0d p=%0d d=%h n=%0d",
                                 $time, o_status, o_found, o_found_position,
                                 o_found_data, o_entry_total);
                        fail_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall  <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 7);
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // builds a well-formed append, mostly accepted
    task automatic gen_append();
        logic [63:0] k;
        if ($urandom_range(0, 9) == 0 && gen_keys.size() > 0) begin
            k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];   // out of order
        end else begin
            k = gen_top + 64'($urandom_range(1, 1000));
            if ($urandom_range(0, 15) == 0) k = gen_top + (rnd64() >> 1);
            if (k <= gen_top && gen_keys.size() > 0) k = rnd64();
        end
        pending_ops.push_back(mk(skt_pkg::t_op_append, k, 6'($urandom), $urandom));
        if (gen_keys.size() < DEPTH && (gen_keys.size() == 0 || k > gen_top)) begin
            gen_keys.push_back(k);
            gen_top = k;
        end
    endtask

    initial begin
        int n;
        logic [63:0] k;
        // directed: empty table, extremes, full table, every opcode
        pending_ops.push_back(mk(skt_pkg::t_op_find, '0, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmkey, '1, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '0, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_append, '0, '1, '1));
        pending_ops.push_back(mk(skt_pkg::t_op_append, '0, '0, '0));   // equal key rejected
        pending_ops.push_back(mk(skt_pkg::t_op_append, 64'h8000_0000_0000_0000, '0,
                                 32'h5a5a_a5a5));
        pending_ops.push_back(mk(skt_pkg::t_op_append, '1, '0, 32'ha5a5_5a5a));
        pending_ops.push_back(mk(skt_pkg::t_op_append, 64'h5, '0, '0)); // below last rejected
        pending_ops.push_back(mk(skt_pkg::t_op_find, '1, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_find, '0, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_find, 64'h7, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '1, 6'd63, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, 64'd1, 6'd1, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmkey, '0, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmkey, '1, '0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '0, 6'd0, '0));
        // fill to full, one more append rejected, then drain from the front
        for (int i = 0; i < DEPTH; i++)
            pending_ops.push_back(mk(skt_pkg::t_op_append, 64'(i * 3 + 10), 6'(i),
                                     $urandom));
        pending_ops.push_back(mk(skt_pkg::t_op_append, '1, '0, '1));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '0, 6'd63, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '0, 6'd0, '0));
        pending_ops.push_back(mk(skt_pkg::t_op_rmkey, 64'd13, '0, '0));
        while (1) begin
            // clear by removing at position 0; the last of these reports out of range
            if (pending_ops.size() > 200) break;
            for (int i = 0; i < 62; i++)
                pending_ops.push_back(mk(skt_pkg::t_op_rmpos, rnd64(), 6'd0, '0));
            break;
        end
        pending_ops.push_back(mk(skt_pkg::t_op_rmpos, '0, 6'd0, '0));

        // random part tracks keys itself; table is empty here
        gen_keys.delete();
        gen_top = '0;
        n = 0;
        while (n < 700) begin
            int sel;
            sel = $urandom_range(0, 99);
            if (n > 600) quiet = 1'b1;
            if (sel < 40 || gen_keys.size() < 3) begin
                gen_append();
            end else if (sel < 60) begin
                k = (gen_keys.size() > 0 && $urandom_range(0, 3) != 0) ?
                    gen_keys[$urandom_range(0, gen_keys.size() - 1)] : rnd64();
                pending_ops.push_back(mk(skt_pkg::t_op_find, k, 6'($urandom), $urandom));
            end else if (sel < 78) begin
                int j;
                j = $urandom_range(0, gen_keys.size() - 1);
                if ($urandom_range(0, 4) == 0) begin
                    pending_ops.push_back(mk(skt_pkg::t_op_rmkey, rnd64(), 6'($urandom),
                                             $urandom));
                end else begin
                    pending_ops.push_back(mk(skt_pkg::t_op_rmkey, gen_keys[j],
                                             6'($urandom), $urandom));
                    gen_keys.delete(j);
                end
            end else begin
                int p;
                p = $urandom_range(0, 63);
                pending_ops.push_back(mk(skt_pkg::t_op_rmpos, rnd64(), 6'(p), $urandom));
                if (p < gen_keys.size()) gen_keys.delete(p);
            end
            if (gen_keys.size() > 0) gen_top = gen_keys[$];
            n++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ops.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/skt_pkg.sv
rtl/core/skt_store.sv
rtl/core/sorted_key_table.sv
rtl/core/skt_checker.sv
tb/sorted_key_table_test.sv
